>>> rtl/rv32de_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32de_pkg
// Opcodes, function codes and pipeline types of the RV32 decode-and-execute
// block.
// ----------------------------------------------------------------------------
package rv32de_pkg;

    localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
    localparam logic [6:0] OPC_ITYPE  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] ITYPE_FUNC7 = 7'b1011110;

    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SRL  = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;
    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_WORD = 3'b010;

    localparam int unsigned XLEN = 32;

    typedef enum logic [1:0] {
        FMT_NONE,
        FMT_I,
        FMT_J,
        FMT_S
    } t_fmt;

    typedef enum logic [3:0] {
        OP_ZERO,
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_OR,
        OP_SLT,
        OP_SGE,
        OP_EQ,
        OP_MUL,
        OP_REM
    } t_op;

    // control flags and pass-through fields of one item
    typedef struct packed {
        logic [31:0] imm;
        logic [4:0]  dest;
        logic        reg_write;
        logic        alu_src;
        logic        mem_read;
        logic        mem_write;
        logic        mem_to_reg;
        logic        is_branch;
        logic        is_jump;
        logic        err;
    } t_ctl;

    // remainder datapath state, one quotient bit per stage
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;
        logic        byp;
        logic [31:0] byp_val;
    } t_div;

    typedef struct packed {
        t_ctl        ctl;
        logic [31:0] res;
        logic        use_rem;
        t_div        div;
    } t_pipe;

endpackage
`default_nettype wire

>>> rtl/rv32de_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32de_in_if
// Input channel: instruction word and two register values.
// ----------------------------------------------------------------------------
interface rv32de_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        instruction;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;

    modport source (output valid, output instruction, output first_operand,
                    output second_operand, input ready);
    modport sink   (input valid, input instruction, input first_operand,
                    input second_operand, output ready);
endinterface
`default_nettype wire

>>> rtl/rv32de_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32de_out_if
// Output channel: ALU result, immediate and control flags.
// ----------------------------------------------------------------------------
interface rv32de_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] alu_result;
    logic               zero_flag;
    logic signed [31:0] immediate;
    logic [4:0]         dest_reg;
    logic               reg_write;
    logic               alu_src;
    logic               mem_read;
    logic               mem_write;
    logic               mem_to_reg;
    logic               is_branch;
    logic               is_jump;
    logic               decode_error;

    modport source (output valid, output alu_result, output zero_flag,
                    output immediate, output dest_reg, output reg_write,
                    output alu_src, output mem_read, output mem_write,
                    output mem_to_reg, output is_branch, output is_jump,
                    output decode_error, input ready);
    modport sink   (input valid, input alu_result, input zero_flag,
                    input immediate, input dest_reg, input reg_write,
                    input alu_src, input mem_read, input mem_write,
                    input mem_to_reg, input is_branch, input is_jump,
                    input decode_error, output ready);
endinterface
`default_nettype wire

>>> rtl/rv32_decode_and_execute_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_decode_and_execute_top
// Decodes one RV32IM-subset instruction per item and executes it on the ALU.
// ----------------------------------------------------------------------------
// The block accepts one item per clock while the output is not stalled. Each
// item passes the input register, decode, ALU/multiply, 32 remainder stages
// and the output register; the depth comes from the signed remainder, which
// resolves one quotient bit per stage. Every item takes the same stages, so
// results leave in order. A stall at the output freezes the whole pipeline.
module rv32_decode_and_execute_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    rv32de_in_if.sink         i_in,
    rv32de_out_if.source      o_out
);
    import rv32de_pkg::*;

    localparam int unsigned DIV_STAGES = XLEN;

    logic en;

    logic        r_v0;
    logic [31:0] r_ins;
    logic [31:0] r_a0;
    logic [31:0] r_b0;

    logic        r_v1;
    t_ctl        r_ctl1;
    t_op         r_op1;
    logic [31:0] r_a1;
    logic [31:0] r_b1;

    logic        r_dv [0:DIV_STAGES];
    t_pipe       r_dp [0:DIV_STAGES];
    t_pipe       n_dp [1:DIV_STAGES];

    logic        r_ov;
    t_ctl        r_octl;
    logic [31:0] r_ores;

    // advance everything when the output slot is free or being taken
    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    // stage 0: capture input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in.valid;
        end
        if (en) begin
            r_ins <= i_in.instruction;
            r_a0  <= i_in.first_operand;
            r_b0  <= i_in.second_operand;
        end
    end

    // stage 1: decode
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    t_fmt        fmt;
    logic        shamt;
    t_ctl        n_ctl1;
    t_op         n_op1;
    logic [31:0] n_b1;

    assign opc = r_ins[6:0];
    assign f3  = r_ins[14:12];

    always_comb begin
        fmt   = FMT_NONE;
        shamt = 1'b0;
        case (opc)
            OPC_ITYPE: begin
                fmt   = FMT_I;
                shamt = (f3 == F3_SLL) || (f3 == F3_SRL);
            end
            OPC_JALR:   fmt = (f3 == F3_ADD) ? FMT_I : FMT_NONE;
            OPC_JAL:    fmt = FMT_J;
            OPC_BRANCH: fmt = (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT ||
                               f3 == F3_BGE) ? FMT_S : FMT_NONE;
            OPC_STORE:  fmt = (f3 == F3_WORD) ? FMT_S : FMT_NONE;
            OPC_LOAD:   fmt = (f3 == F3_WORD) ? FMT_I : FMT_NONE;
            default:    fmt = FMT_NONE;
        endcase
    end

    always_comb begin
        n_ctl1      = '0;
        n_ctl1.dest = r_ins[11:7];
        if (opc != OPC_RTYPE) begin
            case (fmt)
                FMT_I: begin
                    if (shamt) begin
                        n_ctl1.imm = {{27{r_ins[24]}}, r_ins[24:20]};
                    end else begin
                        n_ctl1.imm = {{20{r_ins[31]}}, r_ins[31:20]};
                    end
                end
                FMT_J:   n_ctl1.imm = {{12{r_ins[31]}}, r_ins[31:12]};
                FMT_S:   n_ctl1.imm = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
                default: n_ctl1.err = 1'b1;
            endcase
        end
        case (opc)
            OPC_RTYPE: n_ctl1.reg_write = 1'b1;
            OPC_ITYPE: begin
                n_ctl1.reg_write = 1'b1;
                n_ctl1.alu_src   = 1'b1;
            end
            OPC_LOAD: begin
                n_ctl1.reg_write  = 1'b1;
                n_ctl1.alu_src    = 1'b1;
                n_ctl1.mem_read   = 1'b1;
                n_ctl1.mem_to_reg = 1'b1;
            end
            OPC_STORE: begin
                n_ctl1.alu_src   = 1'b1;
                n_ctl1.mem_write = 1'b1;
            end
            OPC_BRANCH: n_ctl1.is_branch = 1'b1;
            OPC_JAL: begin
                n_ctl1.reg_write = 1'b1;
                n_ctl1.is_jump   = 1'b1;
            end
            OPC_JALR: begin
                n_ctl1.reg_write = 1'b1;
                n_ctl1.alu_src   = 1'b1;
                n_ctl1.is_jump   = 1'b1;
            end
            default: ;
        endcase
    end

    assign n_b1 = n_ctl1.alu_src ? n_ctl1.imm : r_b0;
    // I-type forces the base function group
    assign f7   = (opc == OPC_ITYPE) ? ITYPE_FUNC7 : r_ins[31:25];

    // pick the ALU operation
    always_comb begin
        n_op1 = OP_ZERO;
        case (opc)
            OPC_LOAD, OPC_STORE: n_op1 = OP_ADD;
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  n_op1 = OP_SUB;
                    F3_BNE:  n_op1 = OP_EQ;
                    F3_BGE:  n_op1 = OP_SLT;
                    F3_BLT:  n_op1 = OP_SGE;
                    default: n_op1 = OP_ZERO;
                endcase
            end
            OPC_RTYPE, OPC_ITYPE: begin
                if (f7[5]) begin
                    n_op1 = (f3 == F3_ADD) ? OP_SUB : OP_ZERO;
                end else if (f7[0]) begin
                    if (f3 == F3_ADD) begin
                        n_op1 = OP_MUL;
                    end else if (f3 == F3_OR) begin
                        n_op1 = OP_REM;
                    end
                end else begin
                    case (f3)
                        F3_ADD:  n_op1 = OP_ADD;
                        F3_AND:  n_op1 = OP_AND;
                        F3_OR:   n_op1 = OP_OR;
                        F3_SLT:  n_op1 = OP_SLT;
                        default: n_op1 = OP_ZERO;
                    endcase
                end
            end
            default: n_op1 = OP_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r_ctl1 <= n_ctl1;
            r_op1  <= n_op1;
            r_a1   <= r_a0;
            r_b1   <= n_b1;
        end
    end

    // stage 2: simple ALU ops, multiply, remainder setup
    logic  lt;
    t_pipe n_p2;

    assign lt = $signed(r_a1) < $signed(r_b1);

    always_comb begin
        n_p2         = '0;
        n_p2.ctl     = r_ctl1;
        n_p2.use_rem = (r_op1 == OP_REM);
        case (r_op1)
            OP_ADD:  n_p2.res = r_a1 + r_b1;
            OP_SUB:  n_p2.res = r_a1 - r_b1;
            OP_AND:  n_p2.res = r_a1 & r_b1;
            OP_OR:   n_p2.res = r_a1 | r_b1;
            OP_SLT:  n_p2.res = {31'd0, lt};
            OP_SGE:  n_p2.res = {31'd0, !lt};
            OP_EQ:   n_p2.res = {31'd0, r_a1 == r_b1};
            OP_MUL:  n_p2.res = r_a1 * r_b1;
            default: n_p2.res = '0;
        endcase
        n_p2.div.quo = r_a1[31] ? (32'd0 - r_a1) : r_a1;
        n_p2.div.dvs = r_b1[31] ? (32'd0 - r_b1) : r_b1;
        n_p2.div.neg = r_a1[31];
        // divide by zero returns the dividend; the overflow case returns zero
        if (r_b1 == '0) begin
            n_p2.div.byp     = 1'b1;
            n_p2.div.byp_val = r_a1;
        end else if (r_a1 == 32'h8000_0000 && r_b1 == 32'hFFFF_FFFF) begin
            n_p2.div.byp     = 1'b1;
        end
    end

    // one restoring division step
    function automatic t_div div_step(input t_div d);
        t_div        o;
        logic [32:0] rr;
        logic [32:0] diff;
        o    = d;
        rr   = {d.rem, d.quo[31]};
        diff = rr - {1'b0, d.dvs};
        o.rem = diff[32] ? rr[31:0] : diff[31:0];
        o.quo = {d.quo[30:0], 1'b0};
        return o;
    endfunction

    // next value of each remainder stage
    always_comb begin
        for (int k = 1; k <= DIV_STAGES; k++) begin
            n_dp[k]     = r_dp[k-1];
            n_dp[k].div = div_step(r_dp[k-1].div);
        end
    end

    // stages 3..34: remainder, one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_v1;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
        if (en) begin
            r_dp[0] <= n_p2;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_dp[k] <= n_dp[k];
            end
        end
    end

    // final stage: select result, fix sign of remainder
    t_div        fd;
    logic [31:0] n_ores;

    assign fd = r_dp[DIV_STAGES].div;

    always_comb begin
        if (!r_dp[DIV_STAGES].use_rem) begin
            n_ores = r_dp[DIV_STAGES].res;
        end else if (fd.byp) begin
            n_ores = fd.byp_val;
        end else if (fd.neg) begin
            n_ores = 32'd0 - fd.rem;
        end else begin
            n_ores = fd.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[DIV_STAGES];
        end
        if (en) begin
            r_octl <= r_dp[DIV_STAGES].ctl;
            r_ores <= n_ores;
        end
    end

    // drive output item
    assign o_out.valid        = r_ov;
    assign o_out.alu_result   = r_ores;
    assign o_out.zero_flag    = (r_ores == '0);
    assign o_out.immediate    = r_octl.imm;
    assign o_out.dest_reg     = r_octl.dest;
    assign o_out.reg_write    = r_octl.reg_write;
    assign o_out.alu_src      = r_octl.alu_src;
    assign o_out.mem_read     = r_octl.mem_read;
    assign o_out.mem_write    = r_octl.mem_write;
    assign o_out.mem_to_reg   = r_octl.mem_to_reg;
    assign o_out.is_branch    = r_octl.is_branch;
    assign o_out.is_jump      = r_octl.is_jump;
    assign o_out.decode_error = r_octl.err;

endmodule
`default_nettype wire

>>> tb/sv/tb_rv32_decode_and_execute_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32_decode_and_execute_top
// Drives instruction items with random gaps, predicts each result from the
// decode and ALU rules and checks every field in order of arrival. A table of
// directed items comes first, followed by random instructions of all kinds.
// ----------------------------------------------------------------------------
module tb_rv32_decode_and_execute_top;
    import rv32de_pkg::*;

    localparam int N_RANDOM  = 750;
    localparam int LATENCY   = 36;
    localparam int LONG_HOLD = 120;

    // one expected result item
    typedef struct {
        logic [31:0] alu_result;
        logic        zero_flag;
        logic [31:0] immediate;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic        alu_src;
        logic        mem_read;
        logic        mem_write;
        logic        mem_to_reg;
        logic        is_branch;
        logic        is_jump;
        logic        decode_error;
    } t_exec;

    // one directed row; has_fixed marks rows with a typed-in result
    typedef struct {
        logic [31:0] instr;
        logic [31:0] a;
        logic [31:0] b;
        bit          has_fixed;
        logic [31:0] fixed_res;
        logic        fixed_err;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rv32de_in_if  in_ch ();
    rv32de_out_if out_ch ();

    rv32_decode_and_execute_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_exec exec_q[$];
    int    n_fail;
    bit    stim_done;
    bit    hold_req;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // build an instruction word from its fields
    function automatic logic [31:0] mk_instr(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                             logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] sign_rem(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, r;
        if (b == 32'd0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r  = ma % mb;
        return a[31] ? -r : r;
    endfunction

    function automatic logic [31:0] alu_calc(logic [6:0] f7, logic [2:0] f3,
                                             logic [31:0] a, logic [31:0] b);
        if (f7[5]) return (f3 == F3_ADD) ? a - b : 32'd0;
        if (f7[0]) begin
            if (f3 == F3_ADD) return a * b;
            if (f3 == F3_OR) return sign_rem(a, b);
            return 32'd0;
        end
        case (f3)
            F3_ADD:  return a + b;
            F3_AND:  return a & b;
            F3_OR:   return a | b;
            F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] branch_cmp(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        case (f3)
            F3_BEQ:  return a - b;
            F3_BNE:  return {31'd0, a == b};
            F3_BGE:  return {31'd0, $signed(a) < $signed(b)};
            F3_BLT:  return {31'd0, !($signed(a) < $signed(b))};
            default: return 32'd0;
        endcase
    endfunction

    // decode and execute one instruction item
    function automatic t_exec decode_exec(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
        t_exec       e;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [31:0] op2;
        opc = ins[6:0];
        f3  = ins[14:12];
        e = '{default: '0};
        e.dest_reg = ins[11:7];
        if (opc != OPC_RTYPE) begin
            case (opc)
                OPC_ITYPE:
                    if (f3 == F3_SLL || f3 == F3_SRL)
                        e.immediate = {{27{ins[24]}}, ins[24:20]};
                    else
                        e.immediate = {{20{ins[31]}}, ins[31:20]};
                OPC_JALR, OPC_LOAD:
                    if ((opc == OPC_JALR && f3 == F3_ADD) || (opc == OPC_LOAD && f3 == F3_WORD))
                        e.immediate = {{20{ins[31]}}, ins[31:20]};
                    else
                        e.decode_error = 1'b1;
                OPC_JAL:
                    e.immediate = {{12{ins[31]}}, ins[31:12]};
                OPC_BRANCH, OPC_STORE:
                    if ((opc == OPC_STORE && f3 == F3_WORD) || (opc == OPC_BRANCH &&
                        (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE)))
                        e.immediate = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    else
                        e.decode_error = 1'b1;
                default: e.decode_error = 1'b1;
            endcase
        end
        case (opc)
            OPC_RTYPE:  e.reg_write = 1'b1;
            OPC_ITYPE:  begin e.reg_write = 1'b1; e.alu_src = 1'b1; end
            OPC_LOAD:   begin
                e.reg_write = 1'b1; e.alu_src = 1'b1; e.mem_read = 1'b1; e.mem_to_reg = 1'b1;
            end
            OPC_STORE:  begin e.alu_src = 1'b1; e.mem_write = 1'b1; end
            OPC_BRANCH: e.is_branch = 1'b1;
            OPC_JAL:    begin e.reg_write = 1'b1; e.is_jump = 1'b1; end
            OPC_JALR:   begin e.reg_write = 1'b1; e.alu_src = 1'b1; e.is_jump = 1'b1; end
            default: ;
        endcase
        op2 = e.alu_src ? e.immediate : b;
        case (opc)
            OPC_LOAD, OPC_STORE: e.alu_result = a + op2;
            OPC_BRANCH:          e.alu_result = branch_cmp(f3, a, op2);
            OPC_RTYPE:           e.alu_result = alu_calc(ins[31:25], f3, a, op2);
            OPC_ITYPE:           e.alu_result = alu_calc(ITYPE_FUNC7, f3, a, op2);
            default:             e.alu_result = 32'd0;
        endcase
        e.zero_flag = (e.alu_result == 32'd0);
        return e;
    endfunction

    // random operand, biased toward edge values
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // random instruction, mostly known opcodes
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [6:0]  opcs[7];
        opcs = '{OPC_RTYPE, OPC_ITYPE, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_JAL, OPC_JALR};
        w = $urandom;
        if ($urandom_range(0, 9) != 0) w[6:0] = opcs[$urandom_range(0, 6)];
        if (w[6:0] == OPC_RTYPE && $urandom_range(0, 3) != 0)
            case ($urandom_range(0, 2))
                0: w[31:25] = 7'b0000000;
                1: w[31:25] = 7'b0100000;
                default: w[31:25] = 7'b0000001;
            endcase
        return w;
    endfunction

    t_row rows[$];
    logic [31:0] pend_instr, pend_a, pend_b;

    // offer one item and wait for it to be taken
    task automatic send_item(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.instruction    <= ins;
        in_ch.first_operand  <= a;
        in_ch.second_operand <= b;
        exec_q = {exec_q, decode_exec(ins, a, b)};
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stimulus
    initial begin
        t_exec e;
        n_fail    = 0;
        stim_done = 1'b0;
        hold_req  = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.instruction    = '0;
        in_ch.first_operand  = '0;
        in_ch.second_operand = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: extremes, every operation, error codes
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_ADD, 5'd31, OPC_RTYPE),
                         32'h7FFF_FFFF, 32'd1, 1'b1, 32'h8000_0000, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h20, 5'd0, 5'd0, F3_ADD, 5'd1, OPC_RTYPE),
                         32'h8000_0000, 32'd1, 1'b1, 32'h7FFF_FFFF, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h01, 5'd0, 5'd0, F3_ADD, 5'd2, OPC_RTYPE),
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h01, 5'd0, 5'd0, F3_OR, 5'd3, OPC_RTYPE),
                         32'd1234, 32'd0, 1'b1, 32'd1234, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h01, 5'd0, 5'd0, F3_OR, 5'd4, OPC_RTYPE),
                         32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h01, 5'd0, 5'd0, F3_OR, 5'd5, OPC_RTYPE),
                         -32'sd7, 32'd3, 1'b0, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_AND, 5'd6, OPC_RTYPE),
                         32'hF0F0_F0F0, 32'hFF00_FF00, 1'b0, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_OR, 5'd7, OPC_RTYPE),
                         32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 32'hFFFF_FFFF, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_SLT, 5'd8, OPC_RTYPE),
                         32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd1, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_XOR, 5'd9, OPC_RTYPE),
                         32'd5, 32'd6, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h20, 5'd0, 5'd0, F3_OR, 5'd9, OPC_RTYPE),
                         32'd5, 32'd6, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h7F, 5'h1F, 5'd0, F3_ADD, 5'd10, OPC_ITYPE),
                         32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h3F, 5'h1F, 5'd0, F3_SLL, 5'd11, OPC_ITYPE),
                         32'd0, 32'd0, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h01, 5'h10, 5'd0, F3_OR, 5'd12, OPC_ITYPE),
                         32'd3, 32'd0, 1'b0, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h40, 5'd0, 5'd0, F3_WORD, 5'd13, OPC_LOAD),
                         32'd100, 32'd0, 1'b0, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_ADD, 5'd13, OPC_LOAD),
                         32'd100, 32'd0, 1'b1, 32'd100, 1'b1}};
        rows = {rows, t_row'{mk_instr(7'h7F, 5'd0, 5'd0, F3_WORD, 5'h1F, OPC_STORE),
                         32'd1, 32'd0, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_BEQ, 5'd0, OPC_BRANCH),
                         32'd9, 32'd9, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_BNE, 5'd0, OPC_BRANCH),
                         32'd9, 32'd9, 1'b1, 32'd1, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_BLT, 5'd0, OPC_BRANCH),
                         32'h8000_0000, 32'd0, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_BGE, 5'd0, OPC_BRANCH),
                         32'h8000_0000, 32'd0, 1'b1, 32'd1, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h00, 5'd0, 5'd0, F3_WORD, 5'd0, OPC_BRANCH),
                         32'd1, 32'd2, 1'b1, 32'd0, 1'b1}};
        rows = {rows, t_row'{32'hFFFF_F000 | OPC_JAL, 32'd1, 32'd2, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{mk_instr(7'h7F, 5'h1F, 5'd0, F3_ADD, 5'd1, OPC_JALR),
                         32'd1, 32'd2, 1'b1, 32'd0, 1'b0}};
        rows = {rows, t_row'{32'hFFFF_FFFF & {25'h1FF_FFFF, 7'b1011110},
                         32'd1, 32'd2, 1'b1, 32'd0, 1'b1}};

        foreach (rows[i]) begin
            send_item(rows[i].instr, rows[i].a, rows[i].b);
            // typed-in result overrides the predictor for this row
            if (rows[i].has_fixed) begin
                e = exec_q[$];
                e.alu_result   = rows[i].fixed_res;
                e.zero_flag    = (rows[i].fixed_res == 32'd0);
                e.decode_error = rows[i].fixed_err;
                exec_q[$] = e;
            end
        end

        // pause until every expected item has come back
        in_ch.valid <= 1'b0;
        wait (exec_q.size() == 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            // long receiver hold-off while items keep coming
            if (n == 200) hold_req <= 1'b1;
            pend_instr = rand_instr();
            pend_a     = rand_operand();
            pend_b     = rand_operand();
            send_item(pend_instr, pend_a, pend_b);
            if (n == 400) begin
                in_ch.valid <= 1'b0;
                wait (exec_q.size() == 0);
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result sink with random stalls and one long hold-off
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_exec e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (exec_q.size() == 0) begin
                $error("result item with nothing expected");
                n_fail++;
            end else begin
                e = exec_q.pop_front();
                if (out_ch.alu_result !== e.alu_result) begin
                    $error("alu_result exp %h got %h", e.alu_result, out_ch.alu_result);
                    n_fail++;
                end
                if (out_ch.zero_flag !== e.zero_flag) begin
                    $error("zero_flag exp %b got %b", e.zero_flag, out_ch.zero_flag);
                    n_fail++;
                end
                if (out_ch.immediate !== e.immediate) begin
                    $error("immediate exp %h got %h", e.immediate, out_ch.immediate);
                    n_fail++;
                end
                if (out_ch.dest_reg !== e.dest_reg) begin
                    $error("dest_reg exp %0d got %0d", e.dest_reg, out_ch.dest_reg);
                    n_fail++;
                end
                if (out_ch.reg_write !== e.reg_write) begin
                    $error("reg_write exp %b got %b", e.reg_write, out_ch.reg_write);
                    n_fail++;
                end
                if (out_ch.alu_src !== e.alu_src) begin
                    $error("alu_src exp %b got %b", e.alu_src, out_ch.alu_src);
                    n_fail++;
                end
                if (out_ch.mem_read !== e.mem_read) begin
                    $error("mem_read exp %b got %b", e.mem_read, out_ch.mem_read);
                    n_fail++;
                end
                if (out_ch.mem_write !== e.mem_write) begin
                    $error("mem_write exp %b got %b", e.mem_write, out_ch.mem_write);
                    n_fail++;
                end
                if (out_ch.mem_to_reg !== e.mem_to_reg) begin
                    $error("mem_to_reg exp %b got %b", e.mem_to_reg, out_ch.mem_to_reg);
                    n_fail++;
                end
                if (out_ch.is_branch !== e.is_branch) begin
                    $error("is_branch exp %b got %b", e.is_branch, out_ch.is_branch);
                    n_fail++;
                end
                if (out_ch.is_jump !== e.is_jump) begin
                    $error("is_jump exp %b got %b", e.is_jump, out_ch.is_jump);
                    n_fail++;
                end
                if (out_ch.decode_error !== e.decode_error) begin
                    $error("decode_error exp %b got %b", e.decode_error, out_ch.decode_error);
                    n_fail++;
                end
            end
        end
    end

    // drain and report
    initial begin
        wait (stim_done);
        wait (exec_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0 && exec_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> rv32_decode_and_execute_top.f
rtl/rv32de_pkg.sv
rtl/rv32de_in_if.sv
rtl/rv32de_out_if.sv
rtl/rv32_decode_and_execute_top.sv
tb/sv/tb_rv32_decode_and_execute_top.sv
